// ----- rtl/tsfe_pkg.sv -----
`timescale 1ns / 1ps

package tsfe_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int ID_W      = 32;
	localparam int DAY_W     = 32;
	localparam int OUTCOME_W = 2;
	localparam int OP_W      = 3;

	localparam logic ACT_TOGGLE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic [OUTCOME_W-1:0] OUT_REMOVED = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_ADDED   = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_PRESENT = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_ABSENT  = 2'd3;

	localparam logic [OP_W-1:0] OP_IDLE   = 3'd0;
	localparam logic [OP_W-1:0] OP_MATCH  = 3'd1;
	localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
	localparam logic [OP_W-1:0] OP_SHIFT  = 3'd4;
	localparam logic [OP_W-1:0] OP_SWAP   = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [DAY_W-1:0] day;
		logic             del;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic             phase;
		logic [ID_W-1:0]  id;
		logic [DAY_W-1:0] day;
	} cell_cmd_t;

endpackage

// ----- rtl/tsfe_if.sv -----
`timescale 1ns / 1ps

interface tsfe_req_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [tsfe_pkg::ID_W-1:0]  item_id;
	logic [tsfe_pkg::DAY_W-1:0] day_stamp;

	modport source(output valid, action, item_id, day_stamp, input ready);
	modport sink(input valid, action, item_id, day_stamp, output ready);
endinterface

interface tsfe_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tsfe_pkg::OUTCOME_W-1:0] outcome;

	modport source(output valid, outcome, input ready);
	modport sink(input valid, outcome, output ready);
endinterface

// ----- rtl/tsfe_cell.sv -----
`timescale 1ns / 1ps

module tsfe_cell #(
	parameter int INDEX = 0,
	parameter int DEPTH = tsfe_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  tsfe_pkg::cell_cmd_t cmd,
	input  logic                sel,
	input  tsfe_pkg::entry_t    up,
	input  tsfe_pkg::entry_t    down,
	output tsfe_pkg::entry_t    entry,
	output logic                match
);

	localparam logic ODD       = (INDEX % 2) != 0;
	localparam logic IS_TOP    = (INDEX == DEPTH - 1);
	localparam logic IS_BOTTOM = (INDEX == 0);

	tsfe_pkg::entry_t entry_q;
	logic             match_q;
	logic             lower;
	logic             upper;

	// In a swap phase a cell is a pair's lower or upper half, or an unpaired end.
	assign lower = (ODD == cmd.phase) && !IS_TOP;
	assign upper = (ODD != cmd.phase) && !IS_BOTTOM;

	always_ff @(posedge clk) begin
		case (cmd.op)
			tsfe_pkg::OP_MATCH: begin
				match_q <= (entry_q.id == cmd.id) && !entry_q.del;
			end
			tsfe_pkg::OP_MARK: begin
				if (sel) begin
					entry_q.del <= 1'b1;
				end
			end
			tsfe_pkg::OP_APPEND: begin
				if (sel) begin
					entry_q.id  <= cmd.id;
					entry_q.day <= cmd.day;
					entry_q.del <= 1'b0;
				end
			end
			tsfe_pkg::OP_SHIFT: begin
				if (!IS_TOP) begin
					entry_q <= up;
				end
			end
			tsfe_pkg::OP_SWAP: begin
				// A live record moves below a deleted one, so live order is kept.
				if (lower && entry_q.del && !up.del) begin
					entry_q <= up;
				end else if (upper && down.del && !entry_q.del) begin
					entry_q <= down;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ----- rtl/toggle_set_with_fifo_eviction.sv -----
`timescale 1ns / 1ps

// Toggle set over an ordered table of TABLE_DEPTH records held in a row of cells.
// The req channel carries one transaction per operation: action (toggle or query),
// item_id and day_stamp. The rsp channel returns one transaction per request with
// the outcome code (removed, added, present or absent).
// A request is taken only while the block is idle. The cells first compare their
// ids against the key, then a scan walks the used records one per cycle. A query
// or a toggle that removes then answers. A toggle that adds appends a record, and
// on a full table first drops the oldest record, or runs odd-even swap phases to
// compact deleted records out. The worst case is set by the scan and by the swap
// phases.
// The response sits in an output register; a new request is taken while it waits,
// and the next response is held back until the receiver takes the earlier one.
// Reset empties the table at once; no clearing pass is needed.
module toggle_set_with_fifo_eviction #(
	parameter int TABLE_DEPTH = tsfe_pkg::TABLE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tsfe_req_if.sink    req,
	tsfe_rsp_if.source  rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_MATCH   = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_EVICT   = 3'd3;
	localparam logic [2:0] S_COMPACT = 3'd4;
	localparam logic [2:0] S_APPEND  = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] live_q, live_d;
	logic [CNT_W-1:0] ph_q, ph_d;
	logic out_valid_q, out_valid_d;
	logic out_load;

	logic                             action_q;
	logic [tsfe_pkg::ID_W-1:0]        key_q;
	logic [tsfe_pkg::DAY_W-1:0]       day_q;
	logic [tsfe_pkg::OUTCOME_W-1:0]   res_q, res_d;
	logic [tsfe_pkg::OUTCOME_W-1:0]   outcome_q;

	tsfe_pkg::cell_cmd_t cmd;
	logic [IDX_W-1:0]    sel_idx;
	logic [IDX_W-1:0]    kidx;

	tsfe_pkg::entry_t entries  [TABLE_DEPTH];
	tsfe_pkg::entry_t up_arr   [TABLE_DEPTH];
	tsfe_pkg::entry_t down_arr [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] del_vec;
	logic [TABLE_DEPTH-1:0] sel_vec;

	assign kidx = k_q[IDX_W-1:0];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_top
			assign up_arr[i] = entries[i];
		end else begin : g_mid
			assign up_arr[i] = entries[i+1];
		end
		if (i == 0) begin : g_bot
			assign down_arr[i] = entries[i];
		end else begin : g_low
			assign down_arr[i] = entries[i-1];
		end
		assign sel_vec[i] = (sel_idx == IDX_W'(i));
		assign del_vec[i] = entries[i].del;

		tsfe_cell #(
			.INDEX(i),
			.DEPTH(TABLE_DEPTH)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.sel  (sel_vec[i]),
			.up   (up_arr[i]),
			.down (down_arr[i]),
			.entry(entries[i]),
			.match(match_vec[i])
		);
	end

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		k_d         = k_q;
		live_d      = live_q;
		ph_d        = ph_q;
		res_d       = res_q;
		out_valid_d = out_valid_q && !rsp.ready;
		out_load    = 1'b0;
		sel_idx     = '0;
		cmd.op      = tsfe_pkg::OP_IDLE;
		cmd.phase   = ph_q[0];
		cmd.id      = key_q;
		cmd.day     = day_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_MATCH;
					k_d     = '0;
					live_d  = '0;
				end
			end
			S_MATCH: begin
				cmd.op  = tsfe_pkg::OP_MATCH;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (k_q == used_q) begin
					if (action_q == tsfe_pkg::ACT_QUERY) begin
						res_d   = tsfe_pkg::OUT_ABSENT;
						state_d = S_DONE;
					end else if (used_q != CNT_W'(TABLE_DEPTH)) begin
						state_d = S_APPEND;
					end else if (live_q == CNT_W'(TABLE_DEPTH)) begin
						state_d = S_EVICT;
					end else begin
						ph_d    = '0;
						state_d = S_COMPACT;
					end
				end else if (match_vec[kidx]) begin
					if (action_q == tsfe_pkg::ACT_QUERY) begin
						res_d = tsfe_pkg::OUT_PRESENT;
					end else begin
						cmd.op  = tsfe_pkg::OP_MARK;
						sel_idx = kidx;
						res_d   = tsfe_pkg::OUT_REMOVED;
					end
					state_d = S_DONE;
				end else begin
					k_d    = k_q + CNT_W'(1);
					live_d = live_q + CNT_W'(!del_vec[kidx]);
				end
			end
			S_EVICT: begin
				cmd.op  = tsfe_pkg::OP_SHIFT;
				used_d  = CNT_W'(TABLE_DEPTH - 1);
				state_d = S_APPEND;
			end
			S_COMPACT: begin
				cmd.op = tsfe_pkg::OP_SWAP;
				if (ph_q == CNT_W'(TABLE_DEPTH - 1)) begin
					used_d  = live_q;
					state_d = S_APPEND;
				end else begin
					ph_d = ph_q + CNT_W'(1);
				end
			end
			S_APPEND: begin
				cmd.op  = tsfe_pkg::OP_APPEND;
				sel_idx = used_q[IDX_W-1:0];
				used_d  = used_q + CNT_W'(1);
				res_d   = tsfe_pkg::OUT_ADDED;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					out_load    = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			k_q         <= '0;
			live_q      <= '0;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			k_q         <= k_d;
			live_q      <= live_d;
			ph_q        <= ph_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_q <= req.action;
			key_q    <= req.item_id;
			day_q    <= req.day_stamp;
		end
		res_q <= res_d;
		if (out_load) begin
			outcome_q <= res_q;
		end
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.outcome = outcome_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("used count exceeds table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (k_q <= used_q))
		else $error("scan index passed the used count");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("append did not grow the table by one record");

	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && state_d == S_IDLE) |=> rsp.valid)
		else $error("finished transaction did not reach the output register");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_DEPTH = tsfe_pkg::TABLE_DEPTH_DEF;
	localparam int N_ITEMS     = 1550;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_WAIT  = 2 * TABLE_DEPTH + 40;
	localparam int HOLD_AT     = 1100;
	localparam int HOLD_LEN    = 400;

	typedef struct {
		logic                       action;
		logic [tsfe_pkg::ID_W-1:0]  id;
		logic [tsfe_pkg::DAY_W-1:0] day;
	} toggle_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tsfe_req_if req_ch();
	tsfe_rsp_if rsp_ch();

	toggle_set_with_fifo_eviction #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	toggle_req_t                        toggle_requests[$];
	logic [tsfe_pkg::OUTCOME_W-1:0]     expected_outcomes[$];
	logic [tsfe_pkg::ID_W-1:0]          recent_ids[$];
	logic [tsfe_pkg::ID_W-1:0]          id_pool[$];

	logic [tsfe_pkg::ID_W-1:0]  shadow_ids[TABLE_DEPTH];
	logic [tsfe_pkg::DAY_W-1:0] shadow_days[TABLE_DEPTH];
	logic                       shadow_del[TABLE_DEPTH];
	int                         shadow_used = 0;

	int n_accepted = 0;
	int n_responses = 0;
	int n_errors = 0;
	int n_added = 0;
	int n_removed = 0;
	int n_present = 0;
	int n_absent = 0;
	int n_compacted = 0;
	int n_evicted = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	logic [1:0] idle_phase;
	assign idle_phase = (n_accepted < 520) ? 2'd0 : (n_accepted < 1040) ? 2'd1 : 2'd2;

	// The shadow table follows the block: first live match wins, and a full table is
	// compacted before an append, dropping the oldest record if nothing was deleted.
	function automatic logic [tsfe_pkg::OUTCOME_W-1:0] shadow_toggle_set(input logic act,
		input logic [tsfe_pkg::ID_W-1:0] id, input logic [tsfe_pkg::DAY_W-1:0] day);
		int pos;
		int wr;
		pos = -1;
		for (int i = 0; i < shadow_used; i++) begin
			if (pos < 0 && shadow_ids[i] == id && !shadow_del[i]) begin
				pos = i;
			end
		end
		if (act == tsfe_pkg::ACT_QUERY) begin
			if (pos >= 0) begin
				n_present++;
				return tsfe_pkg::OUT_PRESENT;
			end
			n_absent++;
			return tsfe_pkg::OUT_ABSENT;
		end
		if (pos >= 0) begin
			shadow_del[pos] = 1'b1;
			n_removed++;
			return tsfe_pkg::OUT_REMOVED;
		end
		if (shadow_used >= TABLE_DEPTH) begin
			wr = 0;
			for (int rd = 0; rd < TABLE_DEPTH; rd++) begin
				if (!shadow_del[rd]) begin
					shadow_ids[wr] = shadow_ids[rd];
					shadow_days[wr] = shadow_days[rd];
					shadow_del[wr] = 1'b0;
					wr++;
				end
			end
			if (wr >= TABLE_DEPTH) begin
				for (int rd = 1; rd < TABLE_DEPTH; rd++) begin
					shadow_ids[rd-1] = shadow_ids[rd];
					shadow_days[rd-1] = shadow_days[rd];
					shadow_del[rd-1] = shadow_del[rd];
				end
				wr = TABLE_DEPTH - 1;
				n_evicted++;
			end else begin
				n_compacted++;
			end
			shadow_used = wr;
		end
		shadow_ids[shadow_used] = id;
		shadow_days[shadow_used] = day;
		shadow_del[shadow_used] = 1'b0;
		shadow_used++;
		n_added++;
		return tsfe_pkg::OUT_ADDED;
	endfunction

	task automatic queue_request(input logic act, input logic [tsfe_pkg::ID_W-1:0] id,
		input logic [tsfe_pkg::DAY_W-1:0] day);
		toggle_req_t r;
		r.action = act;
		r.id = id;
		r.day = day;
		toggle_requests.push_back(r);
		if (act == tsfe_pkg::ACT_TOGGLE) begin
			recent_ids.push_back(id);
			if (recent_ids.size() > 96) begin
				void'(recent_ids.pop_front());
			end
		end
	endtask

	function automatic logic [tsfe_pkg::DAY_W-1:0] random_day();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return '0;
		end
		if (r < 20) begin
			return '1;
		end
		return $urandom;
	endfunction

	function automatic logic [tsfe_pkg::ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		end
		if (r < 80) begin
			return id_pool[$urandom_range(0, id_pool.size() - 1)];
		end
		return $urandom;
	endfunction

	initial begin
		int kind;
		int burst;
		req_ch.valid = 1'b0;
		req_ch.action = tsfe_pkg::ACT_TOGGLE;
		req_ch.item_id = '0;
		req_ch.day_stamp = '0;
		rsp_ch.ready = 1'b0;

		id_pool.push_back('0);
		id_pool.push_back('1);
		for (int i = 0; i < 22; i++) begin
			id_pool.push_back($urandom);
		end

		// Empty table, extreme ids and days, a deleted record that no longer matches,
		// and a fresh record appended behind its deleted twin.
		queue_request(tsfe_pkg::ACT_QUERY, 32'h0000_0000, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0000, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(tsfe_pkg::ACT_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(tsfe_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0000, 32'h1234_5678);
		queue_request(tsfe_pkg::ACT_QUERY, 32'h0000_0000, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0000, 32'h0000_0007);
		queue_request(tsfe_pkg::ACT_QUERY, 32'h0000_0000, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0000, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0000, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_QUERY, 32'h5555_5555, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_request(tsfe_pkg::ACT_QUERY, 32'hAAAA_AAAA, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'hAAAA_AAAA, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_QUERY, 32'h5555_5555, 32'hFFFF_FFFF);
		queue_request(tsfe_pkg::ACT_QUERY, 32'hAAAA_AAAA, 32'h0000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h0000_0001, 32'h0000_0001);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'h8000_0000, 32'h8000_0000);
		queue_request(tsfe_pkg::ACT_TOGGLE, 32'hFFFF_FFFF, 32'h0000_0000);

		// Bursts of new ids fill the table until the oldest record must go, bursts
		// of removals leave deleted records for the next compaction.
		while (toggle_requests.size() < N_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				burst = $urandom_range(8, 24);
				for (int i = 0; i < burst; i++) begin
					queue_request(tsfe_pkg::ACT_TOGGLE, $urandom, random_day());
				end
			end else if (kind < 20) begin
				burst = $urandom_range(3, 12);
				for (int i = 0; i < burst; i++) begin
					queue_request(tsfe_pkg::ACT_TOGGLE,
						recent_ids[$urandom_range(0, recent_ids.size() - 1)], random_day());
				end
			end else begin
				queue_request(($urandom_range(0, 99) < 40) ? tsfe_pkg::ACT_QUERY
					: tsfe_pkg::ACT_TOGGLE, pick_id(), random_day());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (toggle_requests.size() != 0 || req_ch.valid || expected_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d transactions: %0d added, %0d removed, %0d present, %0d absent.",
			n_accepted, n_added, n_removed, n_present, n_absent);
		$display("Appends to a full table: %0d after compaction, %0d with the oldest dropped.",
			n_compacted, n_evicted);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		bit gap;
		toggle_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_outcomes.push_back(shadow_toggle_set(req_ch.action, req_ch.item_id,
					req_ch.day_stamp));
				n_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				case (idle_phase)
					2'd0: gap = $urandom_range(0, 99) < 13;
					2'd1: gap = $urandom_range(0, 99) < 55;
					default: gap = 1'b0;
				endcase
				if (toggle_requests.size() != 0 && !gap) begin
					nxt = toggle_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.action <= nxt.action;
					req_ch.item_id <= nxt.id;
					req_ch.day_stamp <= nxt.day;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver stall while requests keep coming, so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_responses >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		bit stall;
		logic [tsfe_pkg::OUTCOME_W-1:0] want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_responses++;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual outcome %0d",
						$time, rsp_ch.outcome);
					n_errors++;
				end else begin
					want = expected_outcomes.pop_front();
					if (rsp_ch.outcome !== want) begin
						$display("%0t: outcome mismatch, expected %0d, actual %0d",
							$time, want, rsp_ch.outcome);
						n_errors++;
					end
				end
			end
			case (idle_phase)
				2'd0: stall = $urandom_range(0, 99) < 55;
				2'd1: stall = $urandom_range(0, 99) < 13;
				default: stall = 1'b0;
			endcase
			rsp_ch.ready <= (hold_left == 0) && !stall;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d requests left and %0d responses outstanding",
				$time, toggle_requests.size(), expected_outcomes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

// ----- files.f -----
rtl/tsfe_pkg.sv
rtl/tsfe_if.sv
rtl/tsfe_cell.sv
rtl/toggle_set_with_fifo_eviction.sv
test/tb.sv
